// ===== src/bplf_pkg.sv =====
`default_nettype none
package bplf_pkg;

   localparam int FRAMES    = 16;
   localparam int FRAME_W   = $clog2(FRAMES);
   localparam int PAGE_BITS = 16;
   localparam int FILE_BITS = 4;
   localparam int PIN_W     = 8;
   localparam int STAMP_W   = 32;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int CMD_W     = 3;

   localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(FRAMES - 1);

   // request operation codes
   localparam logic [OP_W-1:0] OP_FETCH      = 3'd0;
   localparam logic [OP_W-1:0] OP_UNPIN      = 3'd1;
   localparam logic [OP_W-1:0] OP_MARK_DIRTY = 3'd2;
   localparam logic [OP_W-1:0] OP_FLUSH_PAGE = 3'd3;
   localparam logic [OP_W-1:0] OP_FLUSH_FILE = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PINNED   = 2'd2;

   // frame table update commands
   localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PIN_INC   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PIN_DEC   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_DIRTY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FILL      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FREE      = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [FILE_BITS-1:0] file_id;
      logic [PAGE_BITS-1:0] page_number;
      logic [3:0]           frame_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [FRAME_W-1:0]   result_frame;
      logic                 hit;
      logic                 fill_needed;
      logic                 writeback;
      logic [FILE_BITS-1:0] writeback_file;
      logic [PAGE_BITS-1:0] writeback_page;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [PIN_W-1:0]     pins;
      logic                 dirty;
      logic [FILE_BITS-1:0] file;
      logic [PAGE_BITS-1:0] page;
      logic [STAMP_W-1:0]   stamp;
   } entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]     kind;
      logic [FRAME_W-1:0]   idx;
      logic [FILE_BITS-1:0] file;
      logic [PAGE_BITS-1:0] page;
      logic [STAMP_W-1:0]   stamp;
   } tbl_cmd_type;

   typedef struct packed {
      logic               hit_found;
      logic [FRAME_W-1:0] hit_idx;
      logic               free_found;
      logic [FRAME_W-1:0] free_idx;
      logic               lru_found;
      logic [FRAME_W-1:0] lru_idx;
   } scan_res_type;

endpackage
`default_nettype wire

// ===== src/bplf_ifs.sv =====
`default_nettype none
interface bplf_req_if;
   logic               valid;
   logic               ready;
   bplf_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bplf_rsp_if;
   logic               valid;
   logic               ready;
   bplf_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/bplf_frame_table.sv =====
`default_nettype none
module bplf_frame_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bplf_pkg::FRAME_W-1:0]      rd_idx,
   output bplf_pkg::entry_type               rd_entry,
   input  bplf_pkg::tbl_cmd_type             cmd
);

   logic                             valid_ff [bplf_pkg::FRAMES];
   logic [bplf_pkg::PIN_W-1:0]       pins_ff  [bplf_pkg::FRAMES];
   logic                             dirty_ff [bplf_pkg::FRAMES];
   logic [bplf_pkg::FILE_BITS-1:0]   file_ff  [bplf_pkg::FRAMES];
   logic [bplf_pkg::PAGE_BITS-1:0]   page_ff  [bplf_pkg::FRAMES];
   logic [bplf_pkg::STAMP_W-1:0]     stamp_ff [bplf_pkg::FRAMES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '{default: 1'b0};
         pins_ff  <= '{default: '0};
      end else begin
         case (cmd.kind)
            bplf_pkg::CMD_PIN_INC: begin
               if (pins_ff[cmd.idx] != '1) begin
                  pins_ff[cmd.idx] <= pins_ff[cmd.idx] + bplf_pkg::PIN_W'(1);
               end
            end
            bplf_pkg::CMD_PIN_DEC: begin
               if (pins_ff[cmd.idx] != '0) begin
                  pins_ff[cmd.idx] <= pins_ff[cmd.idx] - bplf_pkg::PIN_W'(1);
               end
            end
            bplf_pkg::CMD_FILL: begin
               valid_ff[cmd.idx] <= 1'b1;
               pins_ff[cmd.idx]  <= bplf_pkg::PIN_W'(1);
            end
            bplf_pkg::CMD_FREE: begin
               valid_ff[cmd.idx] <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.kind)
         bplf_pkg::CMD_PIN_INC: begin
            stamp_ff[cmd.idx] <= cmd.stamp;
         end
         bplf_pkg::CMD_SET_DIRTY: begin
            dirty_ff[cmd.idx] <= 1'b1;
         end
         bplf_pkg::CMD_FILL: begin
            dirty_ff[cmd.idx] <= 1'b0;
            file_ff[cmd.idx]  <= cmd.file;
            page_ff[cmd.idx]  <= cmd.page;
            stamp_ff[cmd.idx] <= cmd.stamp;
         end
         bplf_pkg::CMD_FREE: begin
            dirty_ff[cmd.idx] <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rd_entry.valid = valid_ff[rd_idx];
      rd_entry.pins  = pins_ff[rd_idx];
      rd_entry.dirty = dirty_ff[rd_idx];
      rd_entry.file  = file_ff[rd_idx];
      rd_entry.page  = page_ff[rd_idx];
      rd_entry.stamp = stamp_ff[rd_idx];
   end

endmodule
`default_nettype wire

// ===== src/bplf_scan_unit.sv =====
`default_nettype none
module bplf_scan_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              step,
   input  logic [bplf_pkg::FRAME_W-1:0]      idx,
   input  bplf_pkg::entry_type               entry,
   input  logic [bplf_pkg::FILE_BITS-1:0]    key_file,
   input  logic [bplf_pkg::PAGE_BITS-1:0]    key_page,
   output bplf_pkg::scan_res_type            res,
   output logic                              file_match
);

   bplf_pkg::scan_res_type           res_ff, res_in;
   logic [bplf_pkg::STAMP_W-1:0]     lru_stamp_ff, lru_stamp_in;
   logic                             tag_match;
   logic                             older;

   assign file_match = entry.valid && (entry.file == key_file);
   assign tag_match  = file_match && (entry.page == key_page);
   // strict compare keeps the lowest index on equal stamps
   assign older      = !res_ff.lru_found || (entry.stamp < lru_stamp_ff);

   always_comb begin
      res_in       = res_ff;
      lru_stamp_in = lru_stamp_ff;
      if (clear) begin
         res_in = '0;
      end else if (step) begin
         if (tag_match && !res_ff.hit_found) begin
            res_in.hit_found = 1'b1;
            res_in.hit_idx   = idx;
         end
         if (!entry.valid && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_idx   = idx;
         end
         if ((entry.pins == '0) && older) begin
            res_in.lru_found = 1'b1;
            res_in.lru_idx   = idx;
            lru_stamp_in     = entry.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      lru_stamp_ff <= lru_stamp_in;
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// ===== src/buffer_pool_lru_frames.sv =====
`default_nettype none
// channel   direction  payload               transfer
// req_ch    in         operation/file/page    valid && ready
// rsp_ch    out        status/frame/wb/last   valid && ready
//
// fetch and flush page walk all frames, one per cycle, through the shared
// compare unit. flush file walks the frames the same way and stalls on a
// dirty frame while the response register is still full. unpin, mark dirty
// and unknown operations skip the walk and go straight to the commit step.
// synchronous reset clears valid marks, pin counts and the touch counter.
// req_ch.ready is high only between transactions.
module buffer_pool_lru_frames (
   input  logic        clock,
   input  logic        reset,
   bplf_req_if.sink    req_ch,
   bplf_rsp_if.source  rsp_ch
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_COMMIT = 3'd2;
   localparam logic [2:0] ST_FFILE  = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0]                       state_ff, state_in;
   bplf_pkg::req_type                req_ff, req_in;
   logic [bplf_pkg::FRAME_W-1:0]     idx_ff, idx_in;
   logic [bplf_pkg::STAMP_W-1:0]     tc_ff, tc_in;
   bplf_pkg::rsp_type                final_ff, final_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bplf_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                             slot_free;
   logic                             load;
   bplf_pkg::rsp_type                load_data;
   logic [bplf_pkg::FRAME_W-1:0]     rd_idx;
   bplf_pkg::entry_type              rd_entry;
   bplf_pkg::tbl_cmd_type            cmd;
   logic                             scan_clear;
   logic                             scan_step;
   bplf_pkg::scan_res_type           scan_res;
   logic                             file_match;
   logic [bplf_pkg::FRAME_W-1:0]     fi_idx;
   logic                             fi_ok;

   bplf_frame_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .cmd      (cmd)
   );

   bplf_scan_unit u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .step       (scan_step),
      .idx        (idx_ff),
      .entry      (rd_entry),
      .key_file   (req_ff.file_id),
      .key_page   (req_ff.page_number),
      .res        (scan_res),
      .file_match (file_match)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign fi_idx    = req_ff.frame_index[bplf_pkg::FRAME_W-1:0];
   assign fi_ok     = int'(req_ff.frame_index) < bplf_pkg::FRAMES;

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      idx_in     = idx_ff;
      tc_in      = tc_ff;
      final_in   = final_ff;
      cmd        = '0;
      cmd.kind   = bplf_pkg::CMD_NONE;
      scan_clear = 1'b0;
      scan_step  = 1'b0;
      rd_idx     = idx_ff;
      load       = 1'b0;
      load_data  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               req_in     = req_ch.payload;
               idx_in     = '0;
               scan_clear = 1'b1;
               case (req_ch.payload.operation)
                  bplf_pkg::OP_FETCH,
                  bplf_pkg::OP_FLUSH_PAGE: state_in = ST_SCAN;
                  bplf_pkg::OP_FLUSH_FILE: state_in = ST_FFILE;
                  default:                 state_in = ST_COMMIT;
               endcase
            end
         end
         ST_SCAN: begin
            scan_step = 1'b1;
            idx_in    = idx_ff + bplf_pkg::FRAME_W'(1);
            if (idx_ff == bplf_pkg::LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // victim or matching frame is read back for its pin count, dirty mark and tag
            rd_idx         = scan_res.hit_found ? scan_res.hit_idx : scan_res.lru_idx;
            final_in       = '0;
            final_in.last  = 1'b1;
            cmd.file       = req_ff.file_id;
            cmd.page       = req_ff.page_number;
            cmd.stamp      = tc_ff;
            case (req_ff.operation)
               bplf_pkg::OP_FETCH: begin
                  if (scan_res.hit_found) begin
                     cmd.kind              = bplf_pkg::CMD_PIN_INC;
                     cmd.idx               = scan_res.hit_idx;
                     tc_in                 = tc_ff + bplf_pkg::STAMP_W'(1);
                     final_in.result_frame = scan_res.hit_idx;
                     final_in.hit          = 1'b1;
                  end else if (scan_res.free_found) begin
                     cmd.kind              = bplf_pkg::CMD_FILL;
                     cmd.idx               = scan_res.free_idx;
                     tc_in                 = tc_ff + bplf_pkg::STAMP_W'(1);
                     final_in.result_frame = scan_res.free_idx;
                     final_in.fill_needed  = 1'b1;
                  end else if (scan_res.lru_found) begin
                     cmd.kind              = bplf_pkg::CMD_FILL;
                     cmd.idx               = scan_res.lru_idx;
                     tc_in                 = tc_ff + bplf_pkg::STAMP_W'(1);
                     final_in.result_frame = scan_res.lru_idx;
                     final_in.fill_needed  = 1'b1;
                     if (rd_entry.dirty) begin
                        final_in.writeback      = 1'b1;
                        final_in.writeback_file = rd_entry.file;
                        final_in.writeback_page = rd_entry.page;
                     end
                  end else begin
                     final_in.status = bplf_pkg::STATUS_NO_FRAME;
                  end
               end
               bplf_pkg::OP_UNPIN: begin
                  if (fi_ok) begin
                     cmd.kind = bplf_pkg::CMD_PIN_DEC;
                     cmd.idx  = fi_idx;
                  end
               end
               bplf_pkg::OP_MARK_DIRTY: begin
                  if (fi_ok) begin
                     cmd.kind = bplf_pkg::CMD_SET_DIRTY;
                     cmd.idx  = fi_idx;
                  end
               end
               bplf_pkg::OP_FLUSH_PAGE: begin
                  if (scan_res.hit_found) begin
                     if (rd_entry.pins != '0) begin
                        final_in.status = bplf_pkg::STATUS_PINNED;
                     end else begin
                        cmd.kind = bplf_pkg::CMD_FREE;
                        cmd.idx  = scan_res.hit_idx;
                        if (rd_entry.dirty) begin
                           final_in.writeback      = 1'b1;
                           final_in.writeback_file = rd_entry.file;
                           final_in.writeback_page = rd_entry.page;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_RESP;
         end
         ST_FFILE: begin
            // hold on a dirty frame until the response register can take it
            if (!(file_match && rd_entry.dirty && !slot_free)) begin
               if (file_match) begin
                  cmd.kind = bplf_pkg::CMD_FREE;
                  cmd.idx  = idx_ff;
                  if (rd_entry.dirty) begin
                     load                     = 1'b1;
                     load_data.writeback      = 1'b1;
                     load_data.writeback_file = rd_entry.file;
                     load_data.writeback_page = rd_entry.page;
                  end
               end
               idx_in = idx_ff + bplf_pkg::FRAME_W'(1);
               if (idx_ff == bplf_pkg::LAST_IDX) begin
                  idx_in        = '0;
                  final_in      = '0;
                  final_in.last = 1'b1;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               load      = 1'b1;
               load_data = final_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tc_ff        <= tc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      final_ff    <= final_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // a non-final response only comes out of a file flush still in progress
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> (state_ff == ST_FFILE || state_ff == ST_RESP))
      else $error("non-final response outside a file flush");

   // the touch counter moves only when a fetch commits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COMMIT) |=> $stable(tc_ff))
      else $error("touch counter changed outside commit");

   // an accepted request always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle after accepting a request");

   // a fetch never reports both a hit and a fill
   assert property (@(posedge clock) disable iff (reset)
      load |-> !(load_data.hit && load_data.fill_needed))
      else $error("response marks both hit and fill");

endmodule
`default_nettype wire

// ===== dv/bplf_frame_checker.sv =====
`timescale 1ns / 100ps
module bplf_frame_checker (
   input  logic clock,
   input  logic reset,
   bplf_req_if  req_ch,
   bplf_rsp_if  rsp_ch,
   output int   failures,
   output int   pending,
   output int   rsp_checked,
   output int   hit_count,
   output int   fill_count,
   output int   writeback_count,
   output int   no_frame_count
);

   // shadow copy of the frame table
   logic                           tbl_valid [bplf_pkg::FRAMES];
   logic [bplf_pkg::PIN_W-1:0]     tbl_pins  [bplf_pkg::FRAMES];
   logic                           tbl_dirty [bplf_pkg::FRAMES];
   logic [bplf_pkg::FILE_BITS-1:0] tbl_file  [bplf_pkg::FRAMES];
   logic [bplf_pkg::PAGE_BITS-1:0] tbl_page  [bplf_pkg::FRAMES];
   logic [bplf_pkg::STAMP_W-1:0]   tbl_stamp [bplf_pkg::FRAMES];
   logic [bplf_pkg::STAMP_W-1:0]   touch_count;

   bplf_pkg::rsp_type expected_rsps [$];
   bplf_pkg::rsp_type got;
   bplf_pkg::rsp_type want;

   assign pending = expected_rsps.size();

   task automatic clear_table();
      for (int i = 0; i < bplf_pkg::FRAMES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_pins[i]  = '0;
         tbl_dirty[i] = 1'b0;
         tbl_file[i]  = '0;
         tbl_page[i]  = '0;
         tbl_stamp[i] = '0;
      end
      touch_count = '0;
   endtask

   task automatic stamp_frame(input int idx);
      tbl_stamp[idx] = touch_count;
      touch_count    = touch_count + 1'b1;
   endtask

   function automatic int find_page(input logic [bplf_pkg::FILE_BITS-1:0] fid,
                                    input logic [bplf_pkg::PAGE_BITS-1:0] pg);
      int found;
      found = -1;
      for (int i = 0; i < bplf_pkg::FRAMES; i++)
         if (found < 0 && tbl_valid[i] && tbl_file[i] == fid && tbl_page[i] == pg)
            found = i;
      return found;
   endfunction

   // applies one request to the shadow table and queues the responses it causes
   task automatic predict_frame_table(input bplf_pkg::req_type r);
      bplf_pkg::rsp_type e;
      int      hit_at;
      int      victim;
      e        = '0;
      e.status = bplf_pkg::STATUS_OK;
      e.last   = 1'b1;
      victim   = -1;
      case (r.operation)
         bplf_pkg::OP_FETCH: begin
            hit_at = find_page(r.file_id, r.page_number);
            if (hit_at >= 0) begin
               if (tbl_pins[hit_at] != '1)
                  tbl_pins[hit_at] = tbl_pins[hit_at] + 1'b1;
               stamp_frame(hit_at);
               e.hit          = 1'b1;
               e.result_frame = bplf_pkg::FRAME_W'(hit_at);
            end else begin
               for (int i = 0; i < bplf_pkg::FRAMES; i++)
                  if (victim < 0 && !tbl_valid[i])
                     victim = i;
               if (victim < 0) begin
                  // least recently used unpinned frame, lowest index on ties
                  for (int i = 0; i < bplf_pkg::FRAMES; i++)
                     if (tbl_pins[i] == '0 && (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]))
                        victim = i;
                  if (victim >= 0 && tbl_dirty[victim]) begin
                     e.writeback      = 1'b1;
                     e.writeback_file = tbl_file[victim];
                     e.writeback_page = tbl_page[victim];
                  end
               end
               if (victim < 0) begin
                  e.status = bplf_pkg::STATUS_NO_FRAME;
               end else begin
                  tbl_valid[victim] = 1'b1;
                  tbl_dirty[victim] = 1'b0;
                  tbl_file[victim]  = r.file_id;
                  tbl_page[victim]  = r.page_number;
                  tbl_pins[victim]  = bplf_pkg::PIN_W'(1);
                  stamp_frame(victim);
                  e.fill_needed    = 1'b1;
                  e.result_frame   = bplf_pkg::FRAME_W'(victim);
               end
            end
            expected_rsps.push_back(e);
         end
         bplf_pkg::OP_UNPIN, bplf_pkg::OP_MARK_DIRTY: begin
            if (r.frame_index < bplf_pkg::FRAMES) begin
               if (r.operation == bplf_pkg::OP_UNPIN) begin
                  if (tbl_pins[r.frame_index] != '0)
                     tbl_pins[r.frame_index] = tbl_pins[r.frame_index] - 1'b1;
               end else begin
                  tbl_dirty[r.frame_index] = 1'b1;
               end
            end
            expected_rsps.push_back(e);
         end
         bplf_pkg::OP_FLUSH_PAGE: begin
            hit_at = find_page(r.file_id, r.page_number);
            if (hit_at >= 0) begin
               if (tbl_pins[hit_at] != '0) begin
                  e.status = bplf_pkg::STATUS_PINNED;
               end else begin
                  if (tbl_dirty[hit_at]) begin
                     e.writeback      = 1'b1;
                     e.writeback_file = tbl_file[hit_at];
                     e.writeback_page = tbl_page[hit_at];
                  end
                  tbl_dirty[hit_at] = 1'b0;
                  tbl_valid[hit_at] = 1'b0;
               end
            end
            expected_rsps.push_back(e);
         end
         bplf_pkg::OP_FLUSH_FILE: begin
            for (int i = 0; i < bplf_pkg::FRAMES; i++) begin
               if (tbl_valid[i] && tbl_file[i] == r.file_id) begin
                  if (tbl_dirty[i]) begin
                     e.writeback      = 1'b1;
                     e.writeback_file = tbl_file[i];
                     e.writeback_page = tbl_page[i];
                     e.last           = 1'b0;
                     expected_rsps.push_back(e);
                  end
                  tbl_dirty[i] = 1'b0;
                  tbl_valid[i] = 1'b0;
               end
            end
            e      = '0;
            e.last = 1'b1;
            expected_rsps.push_back(e);
         end
         default: expected_rsps.push_back(e);
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         expected_rsps.delete();
         failures        = 0;
         rsp_checked     = 0;
         hit_count       = 0;
         fill_count      = 0;
         writeback_count = 0;
         no_frame_count  = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_frame_table(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual 0x%0h", $time, got);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status",         32'(want.status),         32'(got.status));
               check_field("result_frame",   32'(want.result_frame),   32'(got.result_frame));
               check_field("hit",            32'(want.hit),            32'(got.hit));
               check_field("fill_needed",    32'(want.fill_needed),    32'(got.fill_needed));
               check_field("writeback",      32'(want.writeback),      32'(got.writeback));
               check_field("writeback_file", 32'(want.writeback_file), 32'(got.writeback_file));
               check_field("writeback_page", 32'(want.writeback_page), 32'(got.writeback_page));
               check_field("last",           32'(want.last),           32'(got.last));
            end
            rsp_checked++;
            if (got.hit === 1'b1)
               hit_count++;
            if (got.fill_needed === 1'b1)
               fill_count++;
            if (got.writeback === 1'b1)
               writeback_count++;
            if (got.status === bplf_pkg::STATUS_NO_FRAME)
               no_frame_count++;
         end
      end
   end

endmodule

// ===== dv/tb_buffer_pool_lru_frames.sv =====
`timescale 1ns / 100ps
module tb_buffer_pool_lru_frames;

   localparam int RANDOM_ITEMS = 120;
   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE_CYCLES = 2 * bplf_pkg::FRAMES + 8;

   logic clock;
   logic reset;
   int   cycles = 0;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   req_sent;
   int   failures;
   int   pending;
   int   rsp_checked;
   int   hit_count;
   int   fill_count;
   int   writeback_count;
   int   no_frame_count;

   bplf_req_if req_ch ();
   bplf_rsp_if rsp_ch ();

   buffer_pool_lru_frames DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bplf_frame_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .failures        (failures),
      .pending         (pending),
      .rsp_checked     (rsp_checked),
      .hit_count       (hit_count),
      .fill_count      (fill_count),
      .writeback_count (writeback_count),
      .no_frame_count  (no_frame_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high across back-to-back transactions; it only drops for a gap
   task automatic issue(input logic [bplf_pkg::OP_W-1:0] op,
                        input logic [bplf_pkg::FILE_BITS-1:0] fid,
                        input logic [bplf_pkg::PAGE_BITS-1:0] pg, input logic [3:0] fidx);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_ch.valid               <= 1'b1;
      req_ch.payload.operation   <= op;
      req_ch.payload.file_id     <= fid;
      req_ch.payload.page_number <= pg;
      req_ch.payload.frame_index <= fidx;
      do @(posedge clock); while (!req_ch.ready);
      req_sent++;
   endtask

   // mostly a small working set so hits, evictions and full tables happen
   function automatic logic [bplf_pkg::FILE_BITS-1:0] pick_file();
      if ($urandom_range(7) == 0)
         return bplf_pkg::FILE_BITS'($urandom_range(15));
      return bplf_pkg::FILE_BITS'($urandom_range(3));
   endfunction

   function automatic logic [bplf_pkg::PAGE_BITS-1:0] pick_page();
      if ($urandom_range(7) == 0)
         return bplf_pkg::PAGE_BITS'($urandom_range(65535));
      return bplf_pkg::PAGE_BITS'($urandom_range(11));
   endfunction

   initial begin
      int random_items;
      int n;
      int sel;
      req_sent       = 0;
      random_items   = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      tx_idle_pct    = 27;
      rx_idle_pct    = 81;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      issue(3'd5, 4'd0, 16'h0000, 4'd0);
      issue(3'd6, 4'd5, 16'h5555, 4'd10);
      issue(3'd7, 4'd15, 16'hFFFF, 4'd15);
      issue(bplf_pkg::OP_UNPIN, 4'd0, 16'h0000, 4'd0);            // pin count already zero
      issue(bplf_pkg::OP_MARK_DIRTY, 4'd0, 16'h0000, 4'd0);       // dirty on a free frame
      issue(bplf_pkg::OP_FETCH, 4'd15, 16'hFFFF, 4'd0);
      issue(bplf_pkg::OP_FETCH, 4'd0, 16'h0000, 4'd15);
      issue(bplf_pkg::OP_FETCH, 4'd15, 16'hFFFF, 4'd0);           // hit
      issue(bplf_pkg::OP_FLUSH_PAGE, 4'd15, 16'hFFFF, 4'd0);      // refused, pinned
      issue(bplf_pkg::OP_UNPIN, 4'd0, 16'h0000, 4'd0);
      issue(bplf_pkg::OP_UNPIN, 4'd0, 16'h0000, 4'd0);
      issue(bplf_pkg::OP_MARK_DIRTY, 4'd0, 16'h0000, 4'd0);
      issue(bplf_pkg::OP_FLUSH_PAGE, 4'd15, 16'hFFFF, 4'd0);      // dirty, written back
      issue(bplf_pkg::OP_FLUSH_PAGE, 4'd15, 16'hFFFF, 4'd0);      // no longer buffered
      issue(bplf_pkg::OP_MARK_DIRTY, 4'd0, 16'h0000, 4'd1);
      issue(bplf_pkg::OP_FETCH, 4'd0, 16'h0001, 4'd0);
      issue(bplf_pkg::OP_MARK_DIRTY, 4'd0, 16'h0000, 4'd0);
      issue(bplf_pkg::OP_FLUSH_FILE, 4'd0, 16'h0000, 4'd0);       // pinned dirty frames still go
      issue(bplf_pkg::OP_FLUSH_FILE, 4'd9, 16'h0000, 4'd0);       // nothing of that file

      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (random_items >= RANDOM_ITEMS / 3) begin
            tx_idle_pct = 81;
            rx_idle_pct = 27;
         end
         sel = $urandom_range(99);
         if (sel < 35) begin
            n = $urandom_range(4, 18);
            repeat (n)
               issue(bplf_pkg::OP_FETCH, pick_file(), pick_page(), 4'($urandom_range(15)));
         end else if (sel < 70) begin
            n = $urandom_range(2, 8);
            repeat (n)
               issue(($urandom_range(3) == 0) ? bplf_pkg::OP_MARK_DIRTY : bplf_pkg::OP_UNPIN,
                     pick_file(), pick_page(), 4'($urandom_range(15)));
         end else if (sel < 85) begin
            n = 1;
            issue(($urandom_range(2) == 0) ? bplf_pkg::OP_FLUSH_FILE : bplf_pkg::OP_FLUSH_PAGE,
                  pick_file(), pick_page(), 4'($urandom_range(15)));
         end else begin
            n = 1;
            issue(3'($urandom_range(7)), 4'($urandom_range(15)),
                  16'($urandom_range(65535)), 4'($urandom_range(15)));
         end
         random_items += n;
      end

      // pin count saturation: empty the table, pin one page past the top, then drop it
      for (int f = 0; f < 16; f++)
         issue(bplf_pkg::OP_FLUSH_FILE, 4'(f), 16'h0000, 4'd0);
      repeat (256) issue(bplf_pkg::OP_FETCH, 4'd5, 16'h1234, 4'd0);
      issue(bplf_pkg::OP_FLUSH_PAGE, 4'd5, 16'h1234, 4'd0);
      issue(bplf_pkg::OP_FLUSH_FILE, 4'd5, 16'h0000, 4'd0);
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked over three idle patterns",
               req_sent, rsp_checked);
      $display("hits %0d, fills %0d, writebacks %0d, no free frame %0d",
               hit_count, fill_count, writeback_count, no_frame_count);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
